FILE: rtl/core/bbo_pkg.sv
// Shared constants, codes and types of the bouncing ball overlay.
package bbo_pkg;

  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned RADIUS_BITS    = 10;
  localparam int unsigned SPEED_BITS     = 8;
  localparam int unsigned COLOR_BITS     = 8;
  localparam int unsigned FUNC_BITS      = 2;
  localparam int unsigned CFG_INDEX_BITS = 2;

  // Item function codes
  localparam logic [FUNC_BITS-1:0] FUNC_PIXEL   = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_RESTART = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_UNUSED  = 2'd3;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BALL_RADIUS  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_SPEED   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X     = 2'd3;

  localparam int unsigned IMAGE_HEIGHT_RESET = 480;
  localparam int unsigned BALL_RADIUS_RESET  = 64;
  localparam int unsigned FALL_SPEED_RESET   = 10;
  localparam int unsigned CENTER_X_RESET     = 320;
  localparam int unsigned BALL_Y_RESET       = IMAGE_HEIGHT_RESET / 2;

  localparam logic [COLOR_BITS-1:0] GREY_HIGH = 8'd80;
  localparam logic [COLOR_BITS-1:0] GREY_FADE = 8'd70;

  // floor(n/3) = (n * DIV3_MUL) >> DIV3_SHIFT, exact for n below 2**15
  localparam int unsigned DIV3_MUL      = 43691;
  localparam int unsigned DIV3_MUL_BITS = 17;
  localparam int unsigned DIV3_SHIFT    = 17;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } rgb_t;

endpackage

FILE: rtl/core/bbo_if.sv
// Channel interfaces: pixel input, pixel output and register write.
interface bbo_pix_in_if #(
  parameter int unsigned COORD_BITS = bbo_pkg::COORD_BITS
) ();
  logic                             valid;
  logic                             ready;
  logic [bbo_pkg::FUNC_BITS-1:0]    func;
  logic [COORD_BITS-1:0]            pix_x;
  logic [COORD_BITS-1:0]            pix_y;
  logic [bbo_pkg::COLOR_BITS-1:0]   bg_red;
  logic [bbo_pkg::COLOR_BITS-1:0]   bg_green;
  logic [bbo_pkg::COLOR_BITS-1:0]   bg_blue;

  modport source (output valid, func, pix_x, pix_y, bg_red, bg_green, bg_blue,
                  input ready);
  modport sink   (input valid, func, pix_x, pix_y, bg_red, bg_green, bg_blue,
                  output ready);
endinterface

interface bbo_pix_out_if ();
  logic                             valid;
  logic                             ready;
  logic [bbo_pkg::COLOR_BITS-1:0]   out_red;
  logic [bbo_pkg::COLOR_BITS-1:0]   out_green;
  logic [bbo_pkg::COLOR_BITS-1:0]   out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface bbo_cfg_if #(
  parameter int unsigned DATA_BITS = bbo_pkg::COORD_BITS
) ();
  logic                                 valid;
  logic                                 ready;
  logic [bbo_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [DATA_BITS-1:0]                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bbo_ball.sv
// Ball position state: frame tick bounce update and restart.
module bbo_ball #(
  parameter int unsigned COORD_BITS  = bbo_pkg::COORD_BITS,
  parameter int unsigned RADIUS_BITS = bbo_pkg::RADIUS_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              tick_i,
  input  logic                              restart_i,
  input  logic [COORD_BITS-1:0]             image_height_i,
  input  logic [RADIUS_BITS-1:0]            ball_radius_i,
  input  logic [bbo_pkg::SPEED_BITS-1:0]    fall_speed_i,
  output logic signed [COORD_BITS+1:0]      ball_y_o
);
  import bbo_pkg::*;

  localparam int unsigned YBits = COORD_BITS + 2;
  localparam int unsigned MaxBits = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int unsigned Bw = MaxBits + 4;

  logic signed [YBits-1:0] ball_y_q, ball_y_d;
  logic                    falling_q, falling_d;

  logic signed [Bw-1:0] y_w, r_w, h_w, s_w;
  logic signed [Bw-1:0] bottom_w, top_w, base_w, step_w;
  logic                 fall_n;

  assign y_w      = Bw'(ball_y_q);
  assign r_w      = signed'(Bw'(ball_radius_i));
  assign h_w      = signed'(Bw'(image_height_i));
  assign s_w      = signed'(Bw'(fall_speed_i));
  assign bottom_w = y_w + r_w;
  assign top_w    = y_w - r_w;

  always_comb begin
    base_w = y_w;
    fall_n = falling_q;
    if (!(bottom_w < h_w)) begin
      fall_n = 1'b0;
      base_w = h_w - r_w - s_w;
    end else if (top_w[Bw-1] || top_w == '0) begin
      fall_n = 1'b1;
      base_w = r_w + s_w;
    end
    step_w = fall_n ? (base_w + s_w) : (base_w - s_w);
  end

  always_comb begin
    ball_y_d  = ball_y_q;
    falling_d = falling_q;
    if (restart_i) begin
      ball_y_d  = {3'b000, image_height_i[COORD_BITS-1:1]};
      falling_d = 1'b1;
    end else if (tick_i) begin
      // wrap within the position width
      ball_y_d  = step_w[YBits-1:0];
      falling_d = fall_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_y_q  <= YBits'(BALL_Y_RESET);
      falling_q <= 1'b1;
    end else begin
      ball_y_q  <= ball_y_d;
      falling_q <= falling_d;
    end
  end

  assign ball_y_o = ball_y_q;

endmodule

FILE: rtl/core/bbo_shade.sv
// Pixel shading pipeline: square and circle tests, highlight grading, select.
module bbo_shade #(
  parameter int unsigned COORD_BITS  = bbo_pkg::COORD_BITS,
  parameter int unsigned RADIUS_BITS = bbo_pkg::RADIUS_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_BITS-1:0]         pix_x_i,
  input  logic [COORD_BITS-1:0]         pix_y_i,
  input  bbo_pkg::rgb_t                 bg_i,
  input  logic signed [COORD_BITS+1:0]  ball_y_i,
  input  logic [COORD_BITS-1:0]         center_x_i,
  input  logic [RADIUS_BITS-1:0]        ball_radius_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bbo_pkg::rgb_t                 out_o
);
  import bbo_pkg::*;

  localparam int unsigned YBits   = COORD_BITS + 2;
  localparam int unsigned MaxBits = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int unsigned W       = MaxBits + 3;
  localparam int unsigned SqW     = 2 * W;
  localparam int unsigned R2W     = 2 * RADIUS_BITS;
  localparam int unsigned R1W     = RADIUS_BITS + 1;
  localparam int unsigned PW      = RADIUS_BITS + 1 + DIV3_MUL_BITS;

  // Radius terms; user changes radius only with pipeline empty, unchecked
  logic [RADIUS_BITS-1:0] hr, hr2, d23_q;
  logic [R1W-1:0]         hr3, two_r;
  logic [PW-1:0]          d23_prod;
  logic [R2W-1:0]         r_sq_q, hr_sq_q, hr2_sq_q;

  assign hr       = ball_radius_i >> 2;
  assign hr3      = R1W'(hr) + {hr, 1'b0};
  assign hr2      = hr3[R1W-1:1];
  assign two_r    = {ball_radius_i, 1'b0};
  assign d23_prod = PW'(two_r) * PW'(DIV3_MUL);

  always_ff @(posedge clk_i) begin
    d23_q    <= d23_prod[DIV3_SHIFT +: RADIUS_BITS];
    r_sq_q   <= R2W'(ball_radius_i) * R2W'(ball_radius_i);
    hr_sq_q  <= R2W'(hr) * R2W'(hr);
    hr2_sq_q <= R2W'(hr2) * R2W'(hr2);
  end

  // Stage valids and ready chain
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic rdy2, rdy3, rdy4, rdy_o;

  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy4       = !v4_q || rdy_o;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (in_ready_o) v1_q <= in_valid_i;
      if (rdy2)       v2_q <= v1_q;
      if (rdy3)       v3_q <= v2_q;
      if (rdy4)       v4_q <= v3_q;
      if (rdy_o)      vo_q <= v4_q;
    end
  end

  // Stage 1: capture pixel and ball position
  logic [COORD_BITS-1:0]    px1_q, py1_q;
  logic signed [YBits-1:0]  cy1_q;
  rgb_t                     bg1_q;

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      px1_q <= pix_x_i;
      py1_q <= pix_y_i;
      cy1_q <= ball_y_i;
      bg1_q <= bg_i;
    end
  end

  // Offsets from the centres and the square test
  logic signed [W-1:0] px_w, py_w, cy_w, cx_w, r_w, nr_w;
  logic signed [W-1:0] dx, dy, ex;
  logic                in_sq;

  assign px_w  = signed'(W'(px1_q));
  assign py_w  = signed'(W'(py1_q));
  assign cy_w  = W'(cy1_q);
  assign cx_w  = signed'(W'(center_x_i));
  assign r_w   = signed'(W'(ball_radius_i));
  assign nr_w  = -r_w;
  assign dx    = px_w - cx_w;
  assign dy    = py_w - cy_w;
  assign ex    = dx - (r_w >>> 1);
  assign in_sq = (dx >= nr_w) && (dx < r_w) && (dy >= nr_w) && (dy < r_w);

  logic signed [W-1:0] dx2_q, dy2_q, ex2_q;
  logic                in_sq2_q;
  rgb_t                bg2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      dx2_q    <= dx;
      dy2_q    <= dy;
      ex2_q    <= ex;
      in_sq2_q <= in_sq;
      bg2_q    <= bg1_q;
    end
  end

  // Stage 2: squares of the offsets, vertical offset to the highlight
  logic [SqW-1:0]      dx_sq, dy_sq, ex_sq;
  logic signed [W-1:0] ey;

  assign dx_sq = $unsigned(SqW'(dx2_q) * SqW'(dx2_q));
  assign dy_sq = $unsigned(SqW'(dy2_q) * SqW'(dy2_q));
  assign ex_sq = $unsigned(SqW'(ex2_q) * SqW'(ex2_q));
  assign ey    = dy2_q + signed'(W'(d23_q));

  logic [SqW-1:0]      dx_sq3_q, dy_sq3_q, ex_sq3_q;
  logic signed [W-1:0] ey3_q;
  logic                in_sq3_q;
  rgb_t                bg3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      dx_sq3_q <= dx_sq;
      dy_sq3_q <= dy_sq;
      ex_sq3_q <= ex_sq;
      ey3_q    <= ey;
      in_sq3_q <= in_sq2_q;
      bg3_q    <= bg2_q;
    end
  end

  // Stage 3: ball circle test, square of the highlight offset
  logic [SqW-1:0] dc, ey_sq;
  logic           in_ball;

  assign dc      = dx_sq3_q + dy_sq3_q;
  assign in_ball = in_sq3_q && (dc <= SqW'(r_sq_q));
  assign ey_sq   = $unsigned(SqW'(ey3_q) * SqW'(ey3_q));

  logic [SqW-1:0] ex_sq4_q, ey_sq4_q;
  logic           in_ball4_q;
  rgb_t           bg4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      ex_sq4_q   <= ex_sq3_q;
      ey_sq4_q   <= ey_sq;
      in_ball4_q <= in_ball;
      bg4_q      <= bg3_q;
    end
  end

  // Stage 4: grade the ball pixel and select against the background
  logic [SqW-1:0]        dh;
  logic [COLOR_BITS-1:0] grey;
  rgb_t                  out_d, out_q;

  assign dh = ex_sq4_q + ey_sq4_q;

  always_comb begin
    priority if (dh <= SqW'(hr_sq_q)) begin
      grey = GREY_HIGH;
    end else if (dh <= SqW'(hr2_sq_q)) begin
      grey = GREY_FADE;
    end else begin
      grey = '0;
    end
    out_d = in_ball4_q ? rgb_t'{red: grey, green: grey, blue: grey} : bg4_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) out_q <= out_d;
  end

  assign out_valid_o = vo_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/core/bouncing_ball_overlay.sv
// Top level of the bouncing ball overlay: registers, ball state, shading pipeline.
//
// Channels: pix_i carries items (func pixel, frame tick or restart) with the
// pixel coordinates and background colour; pix_o returns one colour for each
// pixel item, in order. cfg_i writes the four registers (height, radius,
// speed, centre x) and is always ready; write it only while no pixel is in
// flight.
// Ticks and restarts update the ball state in the cycle they are accepted and
// produce no result; a pixel accepted after them sees the new position.
// Throughput: one item per cycle while pix_o does not stall, set by the
// five-stage shading pipeline (input capture, offsets, squares, circle test,
// grading into the output register).
// Stall: when pix_o.ready is low the pipeline fills its bubbles and then holds;
// pix_i.ready drops only when all five stages are full. Nothing is lost.
// Reset: all stage valids clear, registers take 480/64/10/320, the ball sits
// at line 240 moving down.
module bouncing_ball_overlay #(
  parameter int unsigned COORD_BITS  = bbo_pkg::COORD_BITS,
  parameter int unsigned RADIUS_BITS = bbo_pkg::RADIUS_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbo_pix_in_if.sink  pix_i,
  bbo_pix_out_if.source pix_o,
  bbo_cfg_if.sink     cfg_i
);
  import bbo_pkg::*;

  logic [COORD_BITS-1:0]  image_height_q, center_x_q;
  logic [RADIUS_BITS-1:0] ball_radius_q;
  logic [SPEED_BITS-1:0]  fall_speed_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_height_q <= COORD_BITS'(IMAGE_HEIGHT_RESET);
      ball_radius_q  <= RADIUS_BITS'(BALL_RADIUS_RESET);
      fall_speed_q   <= SPEED_BITS'(FALL_SPEED_RESET);
      center_x_q     <= COORD_BITS'(CENTER_X_RESET);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_IMAGE_HEIGHT: image_height_q <= cfg_i.data[COORD_BITS-1:0];
        REG_BALL_RADIUS:  ball_radius_q  <= cfg_i.data[RADIUS_BITS-1:0];
        REG_FALL_SPEED:   fall_speed_q   <= cfg_i.data[SPEED_BITS-1:0];
        REG_CENTER_X:     center_x_q     <= cfg_i.data[COORD_BITS-1:0];
      endcase
    end
  end

  logic in_acc, tick, restart, pix_valid, shade_ready;
  logic signed [COORD_BITS+1:0] ball_y;
  rgb_t bg, out_pix;

  assign in_acc      = pix_i.valid && shade_ready;
  assign tick        = in_acc && (pix_i.func == FUNC_TICK);
  assign restart     = in_acc && (pix_i.func == FUNC_RESTART);
  assign pix_valid   = pix_i.valid && (pix_i.func == FUNC_PIXEL);
  assign pix_i.ready = shade_ready;
  assign bg          = '{red: pix_i.bg_red, green: pix_i.bg_green, blue: pix_i.bg_blue};

  bbo_ball #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_ball (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .restart_i     (restart),
    .image_height_i(image_height_q),
    .ball_radius_i (ball_radius_q),
    .fall_speed_i  (fall_speed_q),
    .ball_y_o      (ball_y)
  );

  bbo_shade #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_shade (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pix_valid),
    .in_ready_o   (shade_ready),
    .pix_x_i      (pix_i.pix_x),
    .pix_y_i      (pix_i.pix_y),
    .bg_i         (bg),
    .ball_y_i     (ball_y),
    .center_x_i   (center_x_q),
    .ball_radius_i(ball_radius_q),
    .out_valid_o  (pix_o.valid),
    .out_ready_i  (pix_o.ready),
    .out_o        (out_pix)
  );

  assign pix_o.out_red   = out_pix.red;
  assign pix_o.out_green = out_pix.green;
  assign pix_o.out_blue  = out_pix.blue;

endmodule

FILE: rtl/core/bbo_checker.sv
// Port-level assertions for the bouncing ball overlay, bound to the top level.
module bbo_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic [bbo_pkg::FUNC_BITS-1:0]  in_func_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [bbo_pkg::COLOR_BITS-1:0] out_red_i,
  input logic [bbo_pkg::COLOR_BITS-1:0] out_green_i,
  input logic [bbo_pkg::COLOR_BITS-1:0] out_blue_i
);
  import bbo_pkg::*;

  logic pix_acc;
  assign pix_acc = in_valid_i && in_ready_i && (in_func_i == FUNC_PIXEL);

  // No result is offered while in reset
  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  // With no result waiting, the pipeline cannot be full
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // An accepted pixel reaches the output while out_ready stays high
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_i)
    else $error("pixel result missing after five cycles");

  // A stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_red_i)
    && $stable(out_green_i) && $stable(out_blue_i))
    else $error("stalled result changed");

endmodule

bind bouncing_ball_overlay bbo_checker u_bbo_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (pix_i.valid),
  .in_ready_i (pix_i.ready),
  .in_func_i  (pix_i.func),
  .out_valid_i(pix_o.valid),
  .out_ready_i(pix_o.ready),
  .out_red_i  (pix_o.out_red),
  .out_green_i(pix_o.out_green),
  .out_blue_i (pix_o.out_blue)
);

FILE: bench/tb_bouncing_ball_overlay.sv
// Testbench of the bouncing ball overlay: directed and random items, scoreboard on pix_o.
module tb_bouncing_ball_overlay;
  import bbo_pkg::*;

  localparam int unsigned PIPE_LATENCY = 5;
  localparam int unsigned SETTLE_CYCLES = PIPE_LATENCY + 4;
  localparam longint COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [FUNC_BITS-1:0]  func;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [COLOR_BITS-1:0] bg_red;
    logic [COLOR_BITS-1:0] bg_green;
    logic [COLOR_BITS-1:0] bg_blue;
  } pix_item_t;

  logic clk_i;
  logic rst_ni;

  bbo_pix_in_if  pix_in ();
  bbo_pix_out_if pix_out ();
  bbo_cfg_if     cfg ();

  bouncing_ball_overlay uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_in),
    .pix_o  (pix_out),
    .cfg_i  (cfg)
  );

  // Model state of the overlay
  logic [COORD_BITS-1:0]  height_reg;
  logic [RADIUS_BITS-1:0] radius_reg;
  logic [SPEED_BITS-1:0]  speed_reg;
  logic [COORD_BITS-1:0]  center_x_reg;
  logic signed [COORD_BITS+1:0] ball_row;
  logic ball_falling;

  rgb_t overlay_colors[$];

  int error_count;
  int cycle_count;
  bit src_gaps;
  bit sink_gaps;
  int hold_off_req;
  int hold_off_left;
  int sink_gap_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: long hold-off on request, otherwise random gaps while sink_gaps is set
  always @(posedge clk_i) begin
    if (hold_off_req > 0) begin
      hold_off_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_off_left > 0) begin
      pix_out.ready <= 1'b0;
      hold_off_left--;
    end else if (sink_gap_left > 0) begin
      pix_out.ready <= 1'b0;
      sink_gap_left--;
    end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
      pix_out.ready <= 1'b0;
      sink_gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) :
                                                     $urandom_range(0, 2);
    end else begin
      pix_out.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (overlay_colors.size() == 0) begin
        $error("unexpected result transaction: %0d %0d %0d",
               pix_out.out_red, pix_out.out_green, pix_out.out_blue);
        error_count++;
      end else begin
        want = overlay_colors.pop_front();
        if (pix_out.out_red !== want.red) begin
          $error("out_red expected %0d actual %0d", want.red, pix_out.out_red);
          error_count++;
        end
        if (pix_out.out_green !== want.green) begin
          $error("out_green expected %0d actual %0d", want.green, pix_out.out_green);
          error_count++;
        end
        if (pix_out.out_blue !== want.blue) begin
          $error("out_blue expected %0d actual %0d", want.blue, pix_out.out_blue);
          error_count++;
        end
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic rgb_t composite_pixel(pix_item_t it);
    longint r, cx, cy, px, py, hr, hr2, hx, hy, dc, dh;
    rgb_t c;
    r  = longint'(radius_reg);
    cx = longint'(center_x_reg);
    cy = longint'(ball_row);
    px = longint'(it.pix_x);
    py = longint'(it.pix_y);
    hr  = r / 4;
    hr2 = hr * 3 / 2;
    hx  = cx + r / 2;
    hy  = cy - r * 2 / 3;
    c = '{red: it.bg_red, green: it.bg_green, blue: it.bg_blue};
    if (px < cx - r || px >= cx + r || py < cy - r || py >= cy + r) return c;
    dc = (px - cx) * (px - cx) + (py - cy) * (py - cy);
    if (dc > r * r) return c;
    dh = (px - hx) * (px - hx) + (py - hy) * (py - hy);
    if (dh <= hr * hr) c = '{red: GREY_HIGH, green: GREY_HIGH, blue: GREY_HIGH};
    else if (dh <= hr2 * hr2) c = '{red: GREY_FADE, green: GREY_FADE, blue: GREY_FADE};
    else c = '0;
    return c;
  endfunction

  function automatic void bounce_ball();
    longint y, r, s, h;
    y = longint'(ball_row);
    r = longint'(radius_reg);
    s = longint'(speed_reg);
    h = longint'(height_reg);
    if (y + r >= h) begin
      ball_falling = 1'b0;
      y = h - r - s;
    end else if (y - r <= 0) begin
      ball_falling = 1'b1;
      y = r + s;
    end
    y = ball_falling ? y + s : y - s;
    ball_row = y[COORD_BITS+1:0];
  endfunction

  function automatic void track_item(pix_item_t it);
    case (it.func)
      FUNC_PIXEL:   overlay_colors.push_back(composite_pixel(it));
      FUNC_TICK:    bounce_ball();
      FUNC_RESTART: begin
        ball_row = {2'b00, height_reg[COORD_BITS-1:1]};
        ball_falling = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic int src_gap_len();
    int k;
    k = $urandom_range(0, 9);
    if (!src_gaps || k < 6) return 0;
    if (k < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pix_item_t make_item(logic [FUNC_BITS-1:0] func,
                                          longint x, longint y,
                                          logic [COLOR_BITS-1:0] red,
                                          logic [COLOR_BITS-1:0] green,
                                          logic [COLOR_BITS-1:0] blue);
    pix_item_t it;
    it.func = func;
    it.pix_x = clamp_coord(x);
    it.pix_y = clamp_coord(y);
    it.bg_red = red;
    it.bg_green = green;
    it.bg_blue = blue;
    return it;
  endfunction

  task automatic send_item(pix_item_t it);
    int gap;
    pix_in.valid    <= 1'b1;
    pix_in.func     <= it.func;
    pix_in.pix_x    <= it.pix_x;
    pix_in.pix_y    <= it.pix_y;
    pix_in.bg_red   <= it.bg_red;
    pix_in.bg_green <= it.bg_green;
    pix_in.bg_blue  <= it.bg_blue;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    track_item(it);
    gap = src_gap_len();
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_pixel(longint x, longint y);
    send_item(make_item(FUNC_PIXEL, x, y, COLOR_BITS'($urandom), COLOR_BITS'($urandom),
                        COLOR_BITS'($urandom)));
  endtask

  task automatic send_ctrl(logic [FUNC_BITS-1:0] func);
    send_item(make_item(func, longint'($urandom_range(0, COORD_MAX)),
                        longint'($urandom_range(0, COORD_MAX)), COLOR_BITS'($urandom),
                        COLOR_BITS'($urandom), COLOR_BITS'($urandom)));
  endtask

  // Hold the input until every expected color is back, then let the pipe empty
  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    while (overlay_colors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [COORD_BITS-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (index)
      REG_IMAGE_HEIGHT: height_reg   = value;
      REG_BALL_RADIUS:  radius_reg   = value[RADIUS_BITS-1:0];
      REG_FALL_SPEED:   speed_reg    = value[SPEED_BITS-1:0];
      REG_CENTER_X:     center_x_reg = value;
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_ball(longint h, longint r, longint s, longint cx);
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, h[COORD_BITS-1:0]);
    write_reg(REG_BALL_RADIUS, r[COORD_BITS-1:0]);
    write_reg(REG_FALL_SPEED, s[COORD_BITS-1:0]);
    write_reg(REG_CENTER_X, cx[COORD_BITS-1:0]);
  endtask

  task automatic send_random_items(int n);
    int sent, k;
    longint r, cx, cy, hx, hy, spread, jx, jy;
    pix_item_t it;
    sent = 0;
    while (sent < n) begin
      // stretches with and without idling, drawn at random
      if (sent % 64 == 0) begin
        src_gaps  = $urandom_range(0, 3) != 0;
        sink_gaps = $urandom_range(0, 3) != 0;
      end
      it = make_item(FUNC_PIXEL, longint'($urandom_range(0, COORD_MAX)),
                     longint'($urandom_range(0, COORD_MAX)), COLOR_BITS'($urandom),
                     COLOR_BITS'($urandom), COLOR_BITS'($urandom));
      r  = longint'(radius_reg);
      cx = longint'(center_x_reg);
      cy = longint'(ball_row);
      k  = $urandom_range(0, 99);
      if (k < 3) begin
        it.func = FUNC_TICK;
      end else if (k < 4) begin
        it.func = FUNC_RESTART;
      end else if (k < 5) begin
        it.func = FUNC_UNUSED;
      end else if (k >= 25 && k < 45) begin
        // aim at the highlight and fade rings
        hx = cx + r / 2;
        hy = cy - r * 2 / 3;
        spread = (r / 4) * 3 / 2 + 2;
        jx = longint'($urandom_range(0, 2 * spread));
        jy = longint'($urandom_range(0, 2 * spread));
        it.pix_x = clamp_coord(hx - spread + jx);
        it.pix_y = clamp_coord(hy - spread + jy);
      end else if (k >= 45) begin
        spread = r + 2;
        jx = longint'($urandom_range(0, 2 * spread));
        jy = longint'($urandom_range(0, 2 * spread));
        it.pix_x = clamp_coord(cx - spread + jx);
        it.pix_y = clamp_coord(cy - spread + jy);
      end
      send_item(it);
      if (it.func != FUNC_UNUSED) sent++;
    end
  endtask

  task automatic test_reset_defaults();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    send_pixel(320, 240);
    send_pixel(352, 198);
    send_pixel(372, 198);
    send_pixel(256, 240);
    send_pixel(384, 240);
    send_item(make_item(FUNC_PIXEL, 0, 0, 8'h00, 8'h00, 8'h00));
    send_item(make_item(FUNC_PIXEL, COORD_MAX, COORD_MAX, 8'hff, 8'hff, 8'hff));
    send_ctrl(FUNC_UNUSED);
    send_pixel(320, 304);
    send_ctrl(FUNC_TICK);
    send_pixel(320, 186);
  endtask

  task automatic test_bounce();
    set_ball(200, 20, 30, 100);
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    send_ctrl(FUNC_RESTART);
    send_pixel(100, 100);
    repeat (4) send_ctrl(FUNC_TICK);
    send_pixel(100, 120);
    repeat (4) send_ctrl(FUNC_TICK);
    send_pixel(100, 80);
  endtask

  task automatic test_register_extremes();
    // zero height, radius and speed
    set_ball(0, 0, 0, 0);
    send_ctrl(FUNC_RESTART);
    send_ctrl(FUNC_TICK);
    send_pixel(0, 0);
    set_ball(COORD_MAX, (1 << RADIUS_BITS) - 1, (1 << SPEED_BITS) - 1, COORD_MAX);
    send_ctrl(FUNC_RESTART);
    send_pixel(COORD_MAX, 2047);
    send_ctrl(FUNC_TICK);
    send_pixel(COORD_MAX, COORD_MAX);
  endtask

  task automatic test_backpressure();
    set_ball(480, 40, 10, 200);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    send_ctrl(FUNC_RESTART);
    hold_off_req = 300;
    send_random_items(60);
    wait_drained();
  endtask

  task automatic test_random_phases();
    set_ball(480, 64, 10, 320);
    send_random_items(140);
    set_ball($urandom_range(1, COORD_MAX), $urandom_range(1, 60), $urandom_range(0, 40),
             $urandom_range(0, COORD_MAX));
    send_ctrl(FUNC_RESTART);
    send_random_items(140);
    set_ball(COORD_MAX, (1 << RADIUS_BITS) - 1, (1 << SPEED_BITS) - 1, 0);
    send_random_items(140);
    set_ball(1, 1, 0, COORD_MAX);
    send_random_items(140);
    set_ball($urandom_range(100, COORD_MAX), $urandom_range(1, (1 << RADIUS_BITS) - 1),
             $urandom_range(0, (1 << SPEED_BITS) - 1), $urandom_range(0, COORD_MAX));
    send_ctrl(FUNC_RESTART);
    send_random_items(140);
    set_ball($urandom_range(1, 600), $urandom_range(1, 200), $urandom_range(0, 255),
             $urandom_range(0, 800));
    send_random_items(140);
  endtask

  initial begin
    rst_ni          = 1'b0;
    pix_in.valid    = 1'b0;
    pix_in.func     = FUNC_PIXEL;
    pix_in.pix_x    = '0;
    pix_in.pix_y    = '0;
    pix_in.bg_red   = '0;
    pix_in.bg_green = '0;
    pix_in.bg_blue  = '0;
    pix_out.ready   = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = REG_IMAGE_HEIGHT;
    cfg.data        = '0;
    height_reg      = COORD_BITS'(IMAGE_HEIGHT_RESET);
    radius_reg      = RADIUS_BITS'(BALL_RADIUS_RESET);
    speed_reg       = SPEED_BITS'(FALL_SPEED_RESET);
    center_x_reg    = COORD_BITS'(CENTER_X_RESET);
    ball_row        = (COORD_BITS + 2)'(BALL_Y_RESET);
    ball_falling    = 1'b1;
    error_count     = 0;
    cycle_count     = 0;
    src_gaps        = 1'b0;
    sink_gaps       = 1'b0;
    hold_off_req    = 0;
    hold_off_left   = 0;
    sink_gap_left   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_bounce();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    wait_drained();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
